@@ rtl/core/tkm_pkg.sv @@
// ----------------------------------------------------------------------------
// tkm_pkg
// Shared types and constants of the trie keyword matcher: request fields,
// the queued item record, operation, status and state codes.
// ----------------------------------------------------------------------------
package tkm_pkg;

  // default node table size and fixed alphabet
  localparam int NODE_COUNT_DEF = 256;
  localparam int ALPHABET_SIZE  = 256;
  localparam int CHAR_W         = 8;
  localparam int VALUE_W        = 16;
  localparam int COUNT_W        = 16;
  localparam int STATUS_W       = 2;

  // stream widths
  localparam int S_DATA_W = 24;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 40;
  localparam int M_USER_W = 1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // operation codes
  typedef enum logic [1:0] {
    OP_KCHAR = 2'd0,
    OP_KEND  = 2'd1,
    OP_SCAN  = 2'd2
  } op_t;

  // insert status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_ZERO = 2'd3
  } status_t;

  // result kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SCAN   = 1'b1;

  // scan phases
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEAD  = 2'd1,
    PH_WALK  = 2'd2,
    PH_TRAIL = 2'd3
  } phase_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KCHAR,
    ST_KEND,
    ST_VISIT0,
    ST_WALK,
    ST_VISIT
  } state_t;

  // classified request as it sits in the queue
  typedef struct packed {
    logic [1:0]         op;
    logic               start;
    logic [CHAR_W-1:0]  upc;
    logic               white;
    logic               zero;
    logic [VALUE_W-1:0] value;
  } item_t;

  // back end to front end control
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_ctrl_t;

endpackage

@@ rtl/core/trie_keyword_matcher.sv @@
// ----------------------------------------------------------------------------
// trie_keyword_matcher
// Case-insensitive longest-prefix keyword matcher over a trie node table.
//
// channel  dir  fields (low bit up)
// s_*      in   tuser: operation[1:0] start_req[2]; tdata: character[7:0]
//               keyword_value[23:8]
// m_*      out  tuser: kind[0]; tdata: status[1:0] matched_value[17:2]
//               consumed[33:18], zero pad [39:34]
//
// Requests without a table access are finished in the back end's idle state;
// keyword characters, keyword ends and scan bytes that end a walk do one
// child or value table read; a walk step into a child does a child read,
// then a value read, and the first walked byte after leading whitespace
// adds a root value read.
// After reset the back end clears both tables, all NODE_COUNT*256 child
// entries, while s_tready stays low.
// A 4-entry queue parts front and back; the result register takes a new
// result in the cycle the previous one is taken.
// ----------------------------------------------------------------------------
module trie_keyword_matcher #(
  parameter int NODE_COUNT = tkm_pkg::NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // character[7:0], keyword_value[23:8]
  input  logic [tkm_pkg::S_DATA_W-1:0]  s_tdata,
  // operation[1:0], start_req[2]
  input  logic [tkm_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[1:0], matched_value[17:2], consumed[33:18]
  output logic [tkm_pkg::M_DATA_W-1:0]  m_tdata,
  // kind[0]
  output logic [tkm_pkg::M_USER_W-1:0]  m_tuser
);

  tkm_pkg::bk_ctrl_t ctrl;
  tkm_pkg::item_t    head;
  logic              head_valid;

  // request intake and queue
  tkm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .ctrl       (ctrl),
    .head_valid (head_valid),
    .head       (head)
  );

  // trie engine and result register
  tkm_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .ctrl       (ctrl),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

@@ rtl/core/tkm_ram.sv @@
// ----------------------------------------------------------------------------
// tkm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/tkm_front.sv @@
// ----------------------------------------------------------------------------
// tkm_front
// Front end: accepts requests, upper-cases and classifies the byte, and
// holds the classified items in a short queue for the back end.
// ----------------------------------------------------------------------------
module tkm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tkm_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic [tkm_pkg::S_USER_W-1:0]  s_tuser,
  input  tkm_pkg::bk_ctrl_t             ctrl,
  output logic                          head_valid,
  output tkm_pkg::item_t                head
);

  localparam int QPW = $clog2(tkm_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(tkm_pkg::QUEUE_DEPTH + 1);

  tkm_pkg::item_t q [tkm_pkg::QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] fill;
  logic           push;
  logic           pop;
  logic [7:0]     c;
  tkm_pkg::item_t item;

  // classify the incoming byte
  always_comb begin
    c          = s_tdata[7:0];
    item.op    = s_tuser[1:0];
    item.start = s_tuser[2];
    item.value = s_tdata[23:8];
    item.zero  = (c == 8'd0);
    item.white = (c == 8'd32) || (c inside {[8'd9:8'd13]});
    item.upc   = (c inside {[8'd97:8'd122]}) ? (c - 8'd32) : c;
  end

  // handshake, held off while the tables are being cleared
  assign s_tready   = (fill != QCW'(tkm_pkg::QUEUE_DEPTH)) && !ctrl.clearing;
  assign push       = s_tvalid && s_tready;
  assign pop        = ctrl.pop && head_valid;
  assign head_valid = (fill != '0);
  assign head       = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPW'(1);
      if (pop)  rd_ptr <= rd_ptr + QPW'(1);
      if (push && !pop)      fill <= fill + QCW'(1);
      else if (pop && !push) fill <= fill - QCW'(1);
    end
  end

endmodule

@@ rtl/core/tkm_back.sv @@
// ----------------------------------------------------------------------------
// tkm_back
// Back end: sequencer over the child link and node value tables. Inserts
// keywords, walks scan text through the trie and drives the result register.
// ----------------------------------------------------------------------------
module tkm_back #(
  parameter int NODE_COUNT = tkm_pkg::NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  tkm_pkg::item_t                head,
  output tkm_pkg::bk_ctrl_t             ctrl,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tkm_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [tkm_pkg::M_USER_W-1:0]  m_tuser
);

  localparam int NW    = $clog2(NODE_COUNT);
  localparam int FW    = $clog2(NODE_COUNT + 1);
  localparam int CDEPTH = NODE_COUNT * tkm_pkg::ALPHABET_SIZE;
  localparam int AW    = NW + tkm_pkg::CHAR_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(CDEPTH - 1);

  function automatic logic [15:0] sat_inc(input logic [15:0] x);
    return (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

  tkm_pkg::state_t state, state_next;
  tkm_pkg::phase_t phase, phase_next;
  tkm_pkg::item_t  cur, cur_next;

  logic [AW-1:0] clr_cnt, clr_cnt_next;
  logic [NW-1:0] cursor, cursor_next;
  logic          fault, fault_next;
  logic [FW-1:0] next_free, next_free_next;
  logic [NW-1:0] scan_node, scan_node_next;
  logic [15:0]   scan_count, scan_count_next;
  logic [15:0]   best_value, best_value_next;
  logic [15:0]   best_end, best_end_next;
  logic          match_prev, match_prev_next;

  logic          out_valid, out_valid_next;
  logic          out_kind, out_kind_next;
  logic [1:0]    out_status, out_status_next;
  logic [15:0]   out_value, out_value_next;
  logic [15:0]   out_consumed, out_consumed_next;

  logic          c_we;
  logic [AW-1:0] c_waddr;
  logic [NW-1:0] c_wdata;
  logic [AW-1:0] c_raddr;
  logic [NW-1:0] c_rdata;
  logic          v_we;
  logic [NW-1:0] v_waddr;
  logic [15:0]   v_wdata;
  logic [NW-1:0] v_raddr;
  logic [15:0]   v_rdata;

  logic            out_room;
  logic            pop;
  logic            table_full;
  tkm_pkg::phase_t e_phase;
  logic [15:0]     e_count;
  logic            h_skip_kchar;
  logic            h_white_byte;
  logic            cur_white_byte;

  // child link table, node index per (node, byte)
  tkm_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_child (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // node value table
  tkm_ram #(.WIDTH(16), .DEPTH(NODE_COUNT)) u_value (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // request decode helpers
  always_comb begin
    out_room       = !out_valid || m_tready;
    pop            = (state == tkm_pkg::ST_IDLE) && head_valid && out_room;
    table_full     = (next_free == FW'(NODE_COUNT));
    e_phase        = head.start ? tkm_pkg::PH_LEAD : phase;
    e_count        = head.start ? 16'd0 : scan_count;
    h_skip_kchar   = head.zero || head.white || fault;
    h_white_byte   = !head.zero && head.white;
    cur_white_byte = !cur.zero && cur.white;
  end

  assign ctrl.pop      = pop;
  assign ctrl.clearing = (state == tkm_pkg::ST_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tkm_pkg::ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = tkm_pkg::ST_IDLE;
      end
      tkm_pkg::ST_IDLE: begin
        if (pop) begin
          case (head.op)
            tkm_pkg::OP_KCHAR: begin
              if (!h_skip_kchar) state_next = tkm_pkg::ST_KCHAR;
            end
            tkm_pkg::OP_KEND: state_next = tkm_pkg::ST_KEND;
            tkm_pkg::OP_SCAN: begin
              if (e_phase == tkm_pkg::PH_LEAD && !h_white_byte) begin
                state_next = tkm_pkg::ST_VISIT0;
              end else if (e_phase == tkm_pkg::PH_WALK && !head.zero) begin
                state_next = tkm_pkg::ST_WALK;
              end
            end
            default: state_next = tkm_pkg::ST_IDLE;
          endcase
        end
      end
      tkm_pkg::ST_VISIT0: begin
        state_next = cur.zero ? tkm_pkg::ST_IDLE : tkm_pkg::ST_WALK;
      end
      tkm_pkg::ST_WALK: begin
        state_next = (c_rdata != '0) ? tkm_pkg::ST_VISIT : tkm_pkg::ST_IDLE;
      end
      default: state_next = tkm_pkg::ST_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    c_we    = 1'b0;
    c_waddr = {cursor, cur.upc};
    c_wdata = next_free[NW-1:0];
    c_raddr = (head.op == tkm_pkg::OP_KCHAR) ? {cursor, head.upc} : {scan_node, head.upc};
    v_we    = 1'b0;
    v_waddr = next_free[NW-1:0];
    v_wdata = 16'd0;
    v_raddr = (head.op == tkm_pkg::OP_KEND) ? cursor : '0;
    case (state)
      tkm_pkg::ST_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_cnt;
        c_wdata = '0;
        v_we    = (clr_cnt[tkm_pkg::CHAR_W-1:0] == '0);
        v_waddr = clr_cnt[AW-1:tkm_pkg::CHAR_W];
      end
      tkm_pkg::ST_KCHAR: begin
        if (c_rdata == '0 && !table_full) begin
          c_we = 1'b1;
          v_we = 1'b1;
        end
      end
      tkm_pkg::ST_KEND: begin
        v_waddr = cursor;
        v_wdata = cur.value;
        v_we    = !fault && (cur.value != 16'd0) && (v_rdata == 16'd0);
      end
      tkm_pkg::ST_VISIT0: begin
        c_raddr = {NW'(0), cur.upc};
      end
      tkm_pkg::ST_WALK: begin
        v_raddr = c_rdata;
      end
      default: begin
        c_we = 1'b0;
      end
    endcase
  end

  // datapath register updates
  always_comb begin
    logic [15:0] bv;
    logic [15:0] be;
    clr_cnt_next      = clr_cnt;
    cursor_next       = cursor;
    fault_next        = fault;
    next_free_next    = next_free;
    phase_next        = phase;
    scan_node_next    = scan_node;
    scan_count_next   = scan_count;
    best_value_next   = best_value;
    best_end_next     = best_end;
    match_prev_next   = match_prev;
    cur_next          = cur;
    out_valid_next    = out_valid && !m_tready;
    out_kind_next     = out_kind;
    out_status_next   = out_status;
    out_value_next    = out_value;
    out_consumed_next = out_consumed;
    bv                = best_value;
    be                = best_end;
    case (state)
      tkm_pkg::ST_CLEAR: begin
        clr_cnt_next = clr_cnt + AW'(1);
      end
      tkm_pkg::ST_IDLE: begin
        if (pop) begin
          cur_next = head;
          if (head.op == tkm_pkg::OP_SCAN) begin
            // a start request drops any scan in progress
            if (head.start) begin
              phase_next      = tkm_pkg::PH_LEAD;
              scan_node_next  = '0;
              scan_count_next = 16'd0;
              best_value_next = 16'd0;
              best_end_next   = 16'd0;
              match_prev_next = 1'b0;
            end
            case (e_phase)
              tkm_pkg::PH_LEAD: begin
                if (h_white_byte) scan_count_next = sat_inc(e_count);
                else              phase_next      = tkm_pkg::PH_WALK;
              end
              tkm_pkg::PH_WALK: begin
                if (head.zero) begin
                  out_valid_next    = 1'b1;
                  out_kind_next     = tkm_pkg::KIND_SCAN;
                  out_status_next   = tkm_pkg::STAT_OK;
                  out_value_next    = best_value;
                  out_consumed_next = (best_value != 16'd0) ? best_end : 16'd0;
                  phase_next        = tkm_pkg::PH_IDLE;
                end
              end
              tkm_pkg::PH_TRAIL: begin
                if (h_white_byte) begin
                  best_end_next   = sat_inc(best_end);
                  scan_count_next = sat_inc(scan_count);
                end else begin
                  out_valid_next    = 1'b1;
                  out_kind_next     = tkm_pkg::KIND_SCAN;
                  out_status_next   = tkm_pkg::STAT_OK;
                  out_value_next    = best_value;
                  out_consumed_next = (best_value != 16'd0) ? best_end : 16'd0;
                  phase_next        = tkm_pkg::PH_IDLE;
                end
              end
              default: phase_next = phase;
            endcase
          end
        end
      end
      tkm_pkg::ST_KCHAR: begin
        // follow the link, or make a new node
        if (c_rdata != '0) begin
          cursor_next = c_rdata;
        end else if (table_full) begin
          fault_next = 1'b1;
        end else begin
          cursor_next    = next_free[NW-1:0];
          next_free_next = next_free + FW'(1);
        end
      end
      tkm_pkg::ST_KEND: begin
        out_valid_next    = 1'b1;
        out_kind_next     = tkm_pkg::KIND_INSERT;
        out_value_next    = 16'd0;
        out_consumed_next = 16'd0;
        if (fault)                   out_status_next = tkm_pkg::STAT_FULL;
        else if (cur.value == 16'd0) out_status_next = tkm_pkg::STAT_ZERO;
        else if (v_rdata != 16'd0)   out_status_next = tkm_pkg::STAT_DUP;
        else                         out_status_next = tkm_pkg::STAT_OK;
        cursor_next = '0;
        fault_next  = 1'b0;
      end
      tkm_pkg::ST_VISIT0: begin
        // root visit, then end of text or first walk step
        scan_node_next = '0;
        if (v_rdata != 16'd0) begin
          bv              = v_rdata;
          be              = scan_count;
          match_prev_next = 1'b1;
        end else begin
          match_prev_next = 1'b0;
        end
        best_value_next = bv;
        best_end_next   = be;
        if (cur.zero) begin
          out_valid_next    = 1'b1;
          out_kind_next     = tkm_pkg::KIND_SCAN;
          out_status_next   = tkm_pkg::STAT_OK;
          out_value_next    = bv;
          out_consumed_next = (bv != 16'd0) ? be : 16'd0;
          phase_next        = tkm_pkg::PH_IDLE;
        end
      end
      tkm_pkg::ST_WALK: begin
        if (c_rdata != '0) begin
          scan_count_next = sat_inc(scan_count);
          scan_node_next  = c_rdata;
        end else if (match_prev && cur_white_byte) begin
          best_end_next   = sat_inc(best_end);
          scan_count_next = sat_inc(scan_count);
          phase_next      = tkm_pkg::PH_TRAIL;
        end else begin
          out_valid_next    = 1'b1;
          out_kind_next     = tkm_pkg::KIND_SCAN;
          out_status_next   = tkm_pkg::STAT_OK;
          out_value_next    = best_value;
          out_consumed_next = (best_value != 16'd0) ? best_end : 16'd0;
          phase_next        = tkm_pkg::PH_IDLE;
        end
      end
      tkm_pkg::ST_VISIT: begin
        if (v_rdata != 16'd0) begin
          best_value_next = v_rdata;
          best_end_next   = scan_count;
          match_prev_next = 1'b1;
        end else begin
          match_prev_next = 1'b0;
        end
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tkm_pkg::ST_CLEAR;
      clr_cnt    <= '0;
      cursor     <= '0;
      fault      <= 1'b0;
      next_free  <= FW'(1);
      phase      <= tkm_pkg::PH_IDLE;
      scan_node  <= '0;
      scan_count <= 16'd0;
      best_value <= 16'd0;
      best_end   <= 16'd0;
      match_prev <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_cnt    <= clr_cnt_next;
      cursor     <= cursor_next;
      fault      <= fault_next;
      next_free  <= next_free_next;
      phase      <= phase_next;
      scan_node  <= scan_node_next;
      scan_count <= scan_count_next;
      best_value <= best_value_next;
      best_end   <= best_end_next;
      match_prev <= match_prev_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur          <= cur_next;
    out_kind     <= out_kind_next;
    out_status   <= out_status_next;
    out_value    <= out_value_next;
    out_consumed <= out_consumed_next;
  end

  // result port
  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_consumed, out_value, out_status};

  // a fault is only raised once the node table is exhausted
  a_fault_full: assert property (@(posedge clk) disable iff (rst)
    fault |-> next_free == FW'(NODE_COUNT))
    else $error("insert fault with free nodes left");

  // no request leaves the queue while a result is stalled
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !pop)
    else $error("pop while result stalled");

  // a new result comes only from a state that can finish an item
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == tkm_pkg::ST_IDLE ||
                          $past(state) == tkm_pkg::ST_KEND ||
                          $past(state) == tkm_pkg::ST_VISIT0 ||
                          $past(state) == tkm_pkg::ST_WALK))
    else $error("result from unexpected state");

  // an insert status leaves the cursor at the root with no fault
  a_kend_resets: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && out_kind == tkm_pkg::KIND_INSERT) |-> (cursor == '0 && !fault))
    else $error("insert cursor not returned to root");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for trie_keyword_matcher. Keyword inserts and scan
// texts go in over the request stream, and a built-in trie predictor works
// out each insert status and scan result. A directed table runs first, then
// random keyword and text sequences follow. Both stream sides stall at
// random, except during one quiet stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NODES       = tkm_pkg::NODE_COUNT_DEF;
  localparam int ITEMS       = 1800;
  localparam int KW_SLOTS    = 64;
  localparam int KW_MAXLEN   = 6;
  localparam int DRAIN_CYCLES = 32;
  localparam int STALL_LIMIT = 300000;
  localparam logic [1:0] OP_NONE = 2'd3;

  // one request as the stream carries it
  typedef struct packed {
    logic [1:0]  op;
    logic        start;
    logic [7:0]  ch;
    logic [15:0] val;
  } req_t;

  // one result as the stream carries it
  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] value;
    logic [15:0] consumed;
  } result_t;

  // directed row, with the result typed in where it is obvious
  typedef struct packed {
    req_t    req;
    logic    typed;
    result_t want;
  } row_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [tkm_pkg::S_DATA_W-1:0]  s_tdata;
  logic [tkm_pkg::S_USER_W-1:0]  s_tuser;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [tkm_pkg::M_DATA_W-1:0]  m_tdata;
  logic [tkm_pkg::M_USER_W-1:0]  m_tuser;

  trie_keyword_matcher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // predicted trie and scan state
  logic [7:0]      child_of [NODES][256];
  logic [15:0]     node_tag [NODES];
  logic [8:0]      spare_node;
  logic [7:0]      build_at;
  logic            build_bad;
  tkm_pkg::phase_t text_phase;
  logic [7:0]      text_at;
  logic [15:0]     text_len;
  logic [15:0]     top_value;
  logic [15:0]     top_end;
  logic            last_hit;

  result_t outcomes_due [$];
  row_t    opening_rows [$];
  int      mismatches;
  int      sent;
  int      stall_cycles = 0;
  bit      quiet;
  bit      text_open;

  // keywords made of letters, reused to build scan texts
  logic [7:0] kw_chars [KW_SLOTS][KW_MAXLEN];
  int         kw_len [KW_SLOTS];
  int         kw_count;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
  endfunction

  function automatic logic [15:0] inc_sat(logic [15:0] x);
    return (x == 16'hFFFF) ? x : x + 16'd1;
  endfunction

  // enter a node and remember it if a keyword ends there
  function automatic void land_on(logic [7:0] node);
    text_at = node;
    if (node_tag[node] != 16'd0) begin
      top_value = node_tag[node];
      top_end   = text_len;
      last_hit  = 1'b1;
    end else begin
      last_hit = 1'b0;
    end
  endfunction

  function automatic result_t finish_text();
    result_t res;
    res.kind     = tkm_pkg::KIND_SCAN;
    res.status   = tkm_pkg::STAT_OK;
    res.value    = top_value;
    res.consumed = (top_value != 16'd0) ? top_end : 16'd0;
    text_phase   = tkm_pkg::PH_IDLE;
    return res;
  endfunction

  // one byte of the trie walk
  function automatic bit step_walk(logic [7:0] c, output result_t res);
    logic [7:0] nxt;
    res = '0;
    if (c == 8'd0) begin
      res = finish_text();
      return 1'b1;
    end
    nxt = child_of[text_at][to_upper(c)];
    if (nxt != 8'd0) begin
      text_len = inc_sat(text_len);
      land_on(nxt);
      return 1'b0;
    end
    if (last_hit && is_space(c)) begin
      top_end    = inc_sat(top_end);
      text_len   = inc_sat(text_len);
      text_phase = tkm_pkg::PH_TRAIL;
      return 1'b0;
    end
    res = finish_text();
    return 1'b1;
  endfunction

  // predictor: updates the trie and scan state, returns 1 if a result is due
  function automatic bit trie_predict(input req_t r, output result_t res);
    logic [7:0] key;
    logic [7:0] nxt;
    res = '0;
    case (r.op)
      tkm_pkg::OP_KCHAR: begin
        if (r.ch != 8'd0 && !is_space(r.ch) && !build_bad) begin
          key = to_upper(r.ch);
          nxt = child_of[build_at][key];
          if (nxt != 8'd0) begin
            build_at = nxt;
          end else if (spare_node >= NODES) begin
            build_bad = 1'b1;
          end else begin
            child_of[build_at][key]  = spare_node[7:0];
            node_tag[spare_node[7:0]] = 16'd0;
            build_at   = spare_node[7:0];
            spare_node = spare_node + 9'd1;
          end
        end
        return 1'b0;
      end
      tkm_pkg::OP_KEND: begin
        res.kind = tkm_pkg::KIND_INSERT;
        if (build_bad) begin
          res.status = tkm_pkg::STAT_FULL;
        end else if (r.val == 16'd0) begin
          res.status = tkm_pkg::STAT_ZERO;
        end else if (node_tag[build_at] != 16'd0) begin
          res.status = tkm_pkg::STAT_DUP;
        end else begin
          node_tag[build_at] = r.val;
          res.status = tkm_pkg::STAT_OK;
        end
        build_at  = 8'd0;
        build_bad = 1'b0;
        return 1'b1;
      end
      tkm_pkg::OP_SCAN: begin
        if (r.start) begin
          text_phase = tkm_pkg::PH_LEAD;
          text_at    = 8'd0;
          text_len   = 16'd0;
          top_value  = 16'd0;
          top_end    = 16'd0;
          last_hit   = 1'b0;
        end
        case (text_phase)
          tkm_pkg::PH_LEAD: begin
            if (r.ch != 8'd0 && is_space(r.ch)) begin
              text_len = inc_sat(text_len);
              return 1'b0;
            end
            text_phase = tkm_pkg::PH_WALK;
            land_on(8'd0);
            return step_walk(r.ch, res);
          end
          tkm_pkg::PH_WALK: begin
            return step_walk(r.ch, res);
          end
          tkm_pkg::PH_TRAIL: begin
            if (r.ch != 8'd0 && is_space(r.ch)) begin
              top_end  = inc_sat(top_end);
              text_len = inc_sat(text_len);
              return 1'b0;
            end
            res = finish_text();
            return 1'b1;
          end
          default: return 1'b0;
        endcase
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic result_t ins_res(tkm_pkg::status_t s);
    result_t res;
    res = '0;
    res.kind   = tkm_pkg::KIND_INSERT;
    res.status = s;
    return res;
  endfunction

  function automatic result_t scan_res(logic [15:0] v, logic [15:0] n);
    result_t res;
    res.kind     = tkm_pkg::KIND_SCAN;
    res.status   = tkm_pkg::STAT_OK;
    res.value    = v;
    res.consumed = n;
    return res;
  endfunction

  function automatic row_t row(logic [1:0] op, logic st, logic [7:0] ch, logic [15:0] val,
                               logic typed, result_t want);
    row_t rw;
    rw.req.op    = op;
    rw.req.start = st;
    rw.req.ch    = ch;
    rw.req.val   = val;
    rw.typed     = typed;
    rw.want      = want;
    return rw;
  endfunction

  // append one row to the directed table
  function automatic void add_row(row_t rw);
    opening_rows = {opening_rows, rw};
  endfunction

  function automatic logic [7:0] ws_pick();
    int idx;
    idx = $urandom_range(5);
    return (idx == 5) ? 8'd32 : 8'(9 + idx);
  endfunction

  function automatic logic [7:0] letter();
    return 8'(8'h41 + $urandom_range(5));
  endfunction

  // random upper or lower case for letters only
  function automatic logic [7:0] mix_case(logic [7:0] c);
    logic [7:0] u;
    u = c & 8'hDF;
    if (u >= 8'h41 && u <= 8'h5A && $urandom_range(1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  function automatic void check_field(string name, int want, int seen);
    if (want != seen) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  // send one request, with random gaps ahead of it, and log its outcome
  task automatic push_request(input req_t r, input logic typed, input result_t want);
    result_t guess;
    logic    hit;
    while (!quiet && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {r.start, r.op};
    s_tdata  <= {r.val, r.ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hit = trie_predict(r, guess);
    if (typed) outcomes_due = {outcomes_due, want};
    else if (hit) outcomes_due = {outcomes_due, guess};
    if (r.op != OP_NONE) sent++;
    @(negedge clk);
  endtask

  task automatic request(logic [1:0] op, logic st, logic [7:0] ch, logic [15:0] val);
    req_t r;
    r.op    = op;
    r.start = st;
    r.ch    = ch;
    r.val   = val;
    push_request(r, 1'b0, '0);
  endtask

  // next byte of the current scan text, start flag on the first one only
  task automatic text_byte(logic [7:0] c);
    request(tkm_pkg::OP_SCAN, text_open, c, 16'($urandom));
    text_open = 1'b0;
  endtask

  // result side stalls
  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 16);
  end

  // result checker
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.kind     = m_tuser[0];
      seen.status   = m_tdata[1:0];
      seen.value    = m_tdata[17:2];
      seen.consumed = m_tdata[33:18];
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected result kind %0d status %0d value %0d consumed %0d",
                 $time, seen.kind, seen.status, seen.value, seen.consumed);
        mismatches++;
      end else begin
        want = outcomes_due.pop_front();
        check_field("kind", want.kind, seen.kind);
        check_field("status", want.status, seen.status);
        check_field("matched_value", want.value, seen.value);
        check_field("consumed", want.consumed, seen.consumed);
      end
    end
  end

  // watchdog on cycles without any transfer, long enough for the table clear
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int          i;
    int          k;
    int          len;
    int          sel;
    bit          wide;
    logic [7:0]  c;
    logic [15:0] val;
    logic [7:0]  word [KW_MAXLEN];

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    mismatches   = 0;
    sent         = 0;
    quiet        = 1'b0;
    text_open    = 1'b0;
    kw_count     = 0;

    // predictor reset
    for (i = 0; i < NODES; i++) begin
      node_tag[i] = 16'd0;
      for (k = 0; k < 256; k++) child_of[i][k] = 8'd0;
    end
    spare_node = 9'd1;
    build_at   = 8'd0;
    build_bad  = 1'b0;
    text_phase = tkm_pkg::PH_IDLE;
    text_at    = 8'd0;
    text_len   = 16'd0;
    top_value  = 16'd0;
    top_end    = 16'd0;
    last_hit   = 1'b0;

    // directed table
    add_row(row(tkm_pkg::OP_KEND,  1'b0, 8'h00, 16'h0000, 1'b1, ins_res(tkm_pkg::STAT_ZERO)));
    add_row(row(tkm_pkg::OP_SCAN,  1'b1, 8'h78, 16'h0000, 1'b1, scan_res(16'd0, 16'd0)));
    // "go" with an ignored blank and an ignored zero byte inside
    add_row(row(tkm_pkg::OP_KCHAR, 1'b0, 8'h67, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_KCHAR, 1'b0, 8'h20, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_KCHAR, 1'b0, 8'h00, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_KCHAR, 1'b0, 8'h6F, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_KEND,  1'b0, 8'h00, 16'hFFFF, 1'b1, ins_res(tkm_pkg::STAT_OK)));
    // same keyword in other case
    add_row(row(tkm_pkg::OP_KCHAR, 1'b0, 8'h67, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_KCHAR, 1'b0, 8'h4F, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_KEND,  1'b0, 8'h00, 16'h0007, 1'b1, ins_res(tkm_pkg::STAT_DUP)));
    // longer keyword "goa"
    add_row(row(tkm_pkg::OP_KCHAR, 1'b0, 8'h47, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_KCHAR, 1'b0, 8'h4F, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_KCHAR, 1'b0, 8'h61, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_KEND,  1'b0, 8'h00, 16'h0001, 1'b1, ins_res(tkm_pkg::STAT_OK)));
    // unused operation and a scan byte while idle, both dropped
    add_row(row(OP_NONE,           1'b1, 8'hFF, 16'hFFFF, 1'b0, '0));
    add_row(row(tkm_pkg::OP_SCAN,  1'b0, 8'h67, 16'h0000, 1'b0, '0));
    // leading tab, match, trailing carriage return kept in the count
    add_row(row(tkm_pkg::OP_SCAN,  1'b1, 8'h09, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_SCAN,  1'b0, 8'h67, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_SCAN,  1'b0, 8'h6F, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_SCAN,  1'b0, 8'h0D, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_SCAN,  1'b0, 8'h62, 16'h0000, 1'b1,
                scan_res(16'hFFFF, 16'd4)));
    // restart in mid scan, longest match wins, zero byte ends the text
    add_row(row(tkm_pkg::OP_SCAN,  1'b1, 8'h67, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_SCAN,  1'b1, 8'h47, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_SCAN,  1'b0, 8'h6F, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_SCAN,  1'b0, 8'h41, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_SCAN,  1'b0, 8'h00, 16'h0000, 1'b1,
                scan_res(16'd1, 16'd3)));
    // empty keyword at the root
    add_row(row(tkm_pkg::OP_KEND,  1'b0, 8'h00, 16'h8000, 1'b1, ins_res(tkm_pkg::STAT_OK)));
    add_row(row(tkm_pkg::OP_SCAN,  1'b1, 8'h20, 16'h0000, 1'b0, '0));
    add_row(row(tkm_pkg::OP_SCAN,  1'b0, 8'h7A, 16'h0000, 1'b1,
                scan_res(16'h8000, 16'd1)));

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (opening_rows[j]) begin
      push_request(opening_rows[j].req, opening_rows[j].typed, opening_rows[j].want);
    end

    // random sequences
    sent = 0;
    while (sent < ITEMS) begin
      quiet = (sent >= 700 && sent < 1000);
      sel = $urandom_range(99);
      if (sel < 40) begin
        // keyword insert
        if (kw_count != 0 && $urandom_range(4) == 0) begin
          k = $urandom_range(((kw_count < KW_SLOTS) ? kw_count : KW_SLOTS) - 1);
          for (i = 0; i < kw_len[k]; i++) begin
            request(tkm_pkg::OP_KCHAR, 1'($urandom_range(1)), mix_case(kw_chars[k][i]),
                    16'($urandom));
          end
        end else begin
          wide = ($urandom_range(1) == 0);
          len  = wide ? $urandom_range(1, KW_MAXLEN) : $urandom_range(1, 4);
          for (i = 0; i < len; i++) begin
            c = wide ? 8'($urandom_range(255)) : mix_case(letter());
            word[i] = c;
            request(tkm_pkg::OP_KCHAR, 1'($urandom_range(1)), c, 16'($urandom));
          end
          if (!wide) begin
            k = kw_count % KW_SLOTS;
            for (i = 0; i < len; i++) kw_chars[k][i] = word[i];
            kw_len[k] = len;
            kw_count++;
          end
        end
        case ($urandom_range(9))
          0: val = 16'h0000;
          1: val = 16'hFFFF;
          default: val = 16'($urandom);
        endcase
        request(tkm_pkg::OP_KEND, 1'($urandom_range(1)), 8'($urandom_range(255)), val);
      end else if (sel < 88) begin
        // scan text built from keywords, letters and whitespace
        text_open = 1'b1;
        repeat ($urandom_range(2)) text_byte(ws_pick());
        repeat ($urandom_range(1, 2)) begin
          if (kw_count != 0 && $urandom_range(3) != 0) begin
            k = $urandom_range(((kw_count < KW_SLOTS) ? kw_count : KW_SLOTS) - 1);
            for (i = 0; i < kw_len[k]; i++) text_byte(mix_case(kw_chars[k][i]));
          end else begin
            repeat ($urandom_range(1, 3)) text_byte(mix_case(letter()));
          end
        end
        if ($urandom_range(1) == 1) repeat ($urandom_range(1, 2)) text_byte(ws_pick());
        case ($urandom_range(3))
          0, 1: text_byte(8'd0);
          2: text_byte(8'($urandom_range(1, 255)));
          default: text_byte(mix_case(letter()));
        endcase
      end else begin
        // noise
        request(2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                16'($urandom));
      end
    end
    quiet = 1'b0;

    s_tvalid <= 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ trie_keyword_matcher.f @@
rtl/core/tkm_pkg.sv
rtl/core/tkm_ram.sv
rtl/core/tkm_front.sv
rtl/core/tkm_back.sv
rtl/core/trie_keyword_matcher.sv
sim/testbench.sv
